// ===== sv/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle implication failed");

`endif

// ===== sv/mvna_pkg.sv =====
package mvna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VIDX_W + 1;
  localparam int COORD_BITS   = 16;
  localparam int WEIGHT_SHIFT = 48;
  localparam int LANES        = 3;

  localparam int EDGE_W    = COORD_BITS + 1;
  localparam int LEN_W     = 2 * EDGE_W;
  localparam int CROSS_W   = 2 * EDGE_W + 1;
  localparam int MAG_W     = 2 * EDGE_W;
  localparam int HALF_W    = LEN_W / 2;
  localparam int PP_W      = LEN_W + LEN_W - HALF_W;
  localparam int DEN_W     = 2 * LEN_W;
  localparam int NUM_W     = MAG_W + WEIGHT_SHIFT;
  localparam int QUO_W     = WEIGHT_SHIFT + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam int SUM_W      = 64;
  localparam int NORM_W     = 31;
  localparam int PROD_W     = 2 * NORM_W;
  localparam int FRAC_SHIFT = 16;
  localparam int OUT_W      = 16;
  localparam int OUT_MAX    = 2 ** (OUT_W - 1) - 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FACE  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef enum logic [1:0] {OP_WRITE, OP_FACE, OP_READ} op_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    op_t   op;
    vidx_t vertex_index;
    vtx_t  coord;
    vidx_t corner_a;
    vidx_t corner_b;
    vidx_t corner_c;
  } item_t;

  typedef struct packed {
    sum_t sx;
    sum_t sy;
    sum_t sz;
    logic pois;
  } acc_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    normal_defined;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LDA, ST_LDB, ST_LDC, ST_LDW, ST_EDGE, ST_PROD, ST_LEN,
    ST_MULA, ST_MULB, ST_MULC, ST_DIV, ST_DWAIT, ST_ACC,
    ST_RDA, ST_RDB, ST_MAX, ST_NORM, ST_SQ, ST_ROOT, ST_NDIV, ST_NWAIT,
    ST_NFIN, ST_OUT
  } state_t;

endpackage

// ===== sv/mesh_vertex_normal_accumulator_unit.sv =====
// vertex write: taken by the back end when it is idle and done there in the same cycle
// face: one pass of the shared divider per corner, skipped when an edge has zero length
// read: normalizing shifts, sum of squares, square root, divider pass; none when undefined
// input queue and result queue of two items each let push and pop run on their own
// reset (synchronous, active high) clears vertex_count and all control; vertex and sum
// memories are not cleared, a vertex must be written before a face or read uses it
module mesh_vertex_normal_accumulator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mvna_pkg::CNT_W-1:0]          cfg_wdata,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          cmd,
  input  logic [mvna_pkg::VIDX_W-1:0]         vertex_index,
  input  logic signed [mvna_pkg::COORD_BITS-1:0] coord_x,
  input  logic signed [mvna_pkg::COORD_BITS-1:0] coord_y,
  input  logic signed [mvna_pkg::COORD_BITS-1:0] coord_z,
  input  logic [mvna_pkg::VIDX_W-1:0]         corner_a,
  input  logic [mvna_pkg::VIDX_W-1:0]         corner_b,
  input  logic [mvna_pkg::VIDX_W-1:0]         corner_c,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [mvna_pkg::OUT_W-1:0]   normal_x,
  output logic signed [mvna_pkg::OUT_W-1:0]   normal_y,
  output logic signed [mvna_pkg::OUT_W-1:0]   normal_z,
  output logic                                normal_defined
);
  import mvna_pkg::*;

  logic              q_valid, take, res_push, res_room, deq;
  item_t             q_item;
  result_t           res, head;
  result_t           omem [QDEPTH];
  logic [QPTR_W-1:0] owptr, orptr;
  logic [QCNT_W-1:0] ocount;

  mvna_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .take         (take)
  );

  mvna_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .take     (take),
    .res_push (res_push),
    .res      (res),
    .res_room (res_room)
  );

  // result queue
  assign res_room = (ocount != QCNT_W'(QDEPTH));
  assign empty    = (ocount == '0);
  assign deq      = pop && !empty;
  assign head     = omem[orptr];

  assign normal_x       = head.normal_x;
  assign normal_y       = head.normal_y;
  assign normal_z       = head.normal_z;
  assign normal_defined = head.normal_defined;

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= '0;
      orptr  <= '0;
      ocount <= '0;
    end else begin
      if (res_push) owptr <= owptr + 1'b1;
      if (deq) orptr <= orptr + 1'b1;
      ocount <= ocount + QCNT_W'(res_push) - QCNT_W'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) omem[owptr] <= res;
  end

endmodule

// ===== sv/mvna_front.sv =====
`include "assert_macros.svh"

module mvna_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mvna_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     cmd,
  input  mvna_pkg::vidx_t                vertex_index,
  input  mvna_pkg::coord_t               coord_x,
  input  mvna_pkg::coord_t               coord_y,
  input  mvna_pkg::coord_t               coord_z,
  input  mvna_pkg::vidx_t                corner_a,
  input  mvna_pkg::vidx_t                corner_b,
  input  mvna_pkg::vidx_t                corner_c,
  output logic                           q_valid,
  output mvna_pkg::item_t                q_item,
  input  logic                           take
);
  import mvna_pkg::*;

  logic [CNT_W-1:0]  vertex_count;
  item_t             qmem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] qcount;
  logic              keep, enq;
  item_t             entry;

  always_comb begin
    entry.vertex_index = vertex_index;
    entry.coord.x      = coord_x;
    entry.coord.y      = coord_y;
    entry.coord.z      = coord_z;
    entry.corner_a     = corner_a;
    entry.corner_b     = corner_b;
    entry.corner_c     = corner_c;
    case (cmd)
      CMD_WRITE: begin
        entry.op = OP_WRITE;
        keep     = 1'b1;
      end
      CMD_FACE: begin
        entry.op = OP_FACE;
        // faces touching a vertex beyond the count in use are dropped
        keep     = (CNT_W'(corner_a) < vertex_count) && (CNT_W'(corner_b) < vertex_count) &&
                   (CNT_W'(corner_c) < vertex_count);
      end
      CMD_READ: begin
        entry.op = OP_READ;
        keep     = 1'b1;
      end
      default: begin
        entry.op = OP_WRITE;
        keep     = 1'b0;
      end
    endcase
  end

  assign full    = (qcount == QCNT_W'(QDEPTH));
  assign enq     = push && !full && keep;
  assign q_valid = (qcount != '0);
  assign q_item  = qmem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      wptr         <= '0;
      rptr         <= '0;
      qcount       <= '0;
    end else begin
      if (cfg_we) vertex_count <= cfg_wdata;
      if (enq) wptr <= wptr + 1'b1;
      if (take) rptr <= rptr + 1'b1;
      qcount <= qcount + QCNT_W'(enq) - QCNT_W'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) qmem[wptr] <= entry;
  end

  `ASSERT_IMPLIES(a_take_nonempty, clk, rst, take, qcount != '0)
  `ASSERT_NEXT(a_full_holds, clk, rst, full && !take, full)

endmodule

// ===== sv/mvna_div.sv =====
`include "assert_macros.svh"

module mvna_div (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           start,
  input  logic [mvna_pkg::LANES-1:0][mvna_pkg::NUM_W-1:0] num,
  input  logic [mvna_pkg::DEN_W-1:0]                     den,
  output logic                                           busy,
  output logic                                           done,
  output logic [mvna_pkg::LANES-1:0][mvna_pkg::QUO_W-1:0] quo
);
  import mvna_pkg::*;

  localparam int RW = DEN_W + 1;

  logic [NUM_W-1:0]     n   [LANES];
  logic [RW-1:0]        r   [LANES];
  logic [RW-1:0]        rs  [LANES];
  logic                 ge  [LANES];
  logic [DEN_W-1:0]     d;
  logic [DIV_CNT_W-1:0] cnt;

  // restoring division, one quotient bit per lane each cycle
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rs[k] = {r[k][RW-2:0], n[k][NUM_W-1]};
      ge[k] = (rs[k] >= {1'b0, d});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d <= den;
      for (int k = 0; k < LANES; k++) begin
        n[k]   <= num[k];
        r[k]   <= '0;
        quo[k] <= '0;
      end
    end else if (busy) begin
      for (int k = 0; k < LANES; k++) begin
        n[k]   <= n[k] << 1;
        r[k]   <= ge[k] ? (rs[k] - {1'b0, d}) : rs[k];
        quo[k] <= {quo[k][QUO_W-2:0], ge[k]};
      end
    end
  end

  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)

endmodule

// ===== sv/mvna_back.sv =====
`include "assert_macros.svh"

module mvna_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  mvna_pkg::item_t   q_item,
  output logic              take,
  output logic              res_push,
  output mvna_pkg::result_t res,
  input  logic              res_room
);
  import mvna_pkg::*;

  state_t state, state_next;
  item_t  itm;

  vtx_t  vmem [MAX_VERTICES];
  acc_t  smem [MAX_VERTICES];
  vtx_t  vrd;
  acc_t  srd;
  vidx_t vaddr, saddr, swaddr;
  logic  vwe, swe;
  acc_t  swdata;

  vtx_t       va, vb, vc, pv, qv, rv;
  logic [1:0] corner;
  vidx_t      pidx;
  coord_t     pc [LANES];
  coord_t     qc [LANES];
  coord_t     rc [LANES];

  logic signed [EDGE_W-1:0] e1 [LANES];
  logic signed [EDGE_W-1:0] e2 [LANES];
  logic signed [LEN_W-1:0]  sq1 [LANES];
  logic signed [LEN_W-1:0]  sq2 [LANES];
  logic signed [LEN_W-1:0]  xp [2*LANES];
  logic signed [CROSS_W-1:0] cr [LANES];
  logic [LEN_W-1:0]  l1, l2;
  logic [MAG_W-1:0]  mag [LANES];
  logic              cneg [LANES];
  logic [PP_W-1:0]   p0, p1;
  logic [DEN_W-1:0]  den_r;
  logic              len_zero;

  logic                                div_start, div_busy, div_done;
  logic [LANES-1:0][NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]                    div_den;
  logic [LANES-1:0][QUO_W-1:0]         div_quo;

  logic [SUM_W-1:0]  t [LANES];
  logic [SUM_W-1:0]  m, v, root, bitv, rb;
  logic              sneg [LANES];
  logic              rpois;
  logic [1:0]        sqcnt;
  logic [PROD_W-1:0] prod;
  result_t           res_r;
  sum_t              s_cur [LANES];
  sum_t              s_new [LANES];
  logic signed [OUT_W-1:0] nout [LANES];
  logic [OUT_W-1:0]        ncap [LANES];

  function automatic sum_t sat_add(sum_t a, sum_t b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1])
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      sat_add = s[SUM_W-1:0];
  endfunction

  // corner roles rotate through a, b, c
  always_comb begin
    case (corner)
      2'd1: begin
        pv = vb; qv = vc; rv = va; pidx = itm.corner_b;
      end
      2'd2: begin
        pv = vc; qv = va; rv = vb; pidx = itm.corner_c;
      end
      default: begin
        pv = va; qv = vb; rv = vc; pidx = itm.corner_a;
      end
    endcase
    pc[0] = pv.x; pc[1] = pv.y; pc[2] = pv.z;
    qc[0] = qv.x; qc[1] = qv.y; qc[2] = qv.z;
    rc[0] = rv.x; rc[1] = rv.y; rc[2] = rv.z;
  end

  always_comb begin
    s_cur[0] = srd.sx;
    s_cur[1] = srd.sy;
    s_cur[2] = srd.sz;
    for (int k = 0; k < LANES; k++) begin
      cr[k]    = CROSS_W'(xp[2*k]) - CROSS_W'(xp[2*k+1]);
      s_new[k] = sat_add(s_cur[k], cneg[k] ? -SUM_W'(div_quo[k]) : SUM_W'(div_quo[k]));
      ncap[k]  = (div_quo[k] > QUO_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : div_quo[k][OUT_W-1:0];
      nout[k]  = sneg[k] ? -ncap[k] : ncap[k];
    end
    len_zero = (l1 == '0) || (l2 == '0);
    rb       = root + bitv;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_FACE: state_next = ST_LDA;
            OP_READ: state_next = ST_RDA;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_LDA:  state_next = ST_LDB;
      ST_LDB:  state_next = ST_LDC;
      ST_LDC:  state_next = ST_LDW;
      ST_LDW:  state_next = ST_EDGE;
      ST_EDGE: state_next = ST_PROD;
      ST_PROD: state_next = ST_LEN;
      ST_LEN:  state_next = ST_MULA;
      ST_MULA: begin
        if (len_zero) state_next = (corner == 2'd2) ? ST_IDLE : ST_EDGE;
        else state_next = ST_MULB;
      end
      ST_MULB:  state_next = ST_MULC;
      ST_MULC:  state_next = ST_DIV;
      ST_DIV:   state_next = ST_DWAIT;
      ST_DWAIT: if (div_done) state_next = ST_ACC;
      ST_ACC:   state_next = (corner == 2'd2) ? ST_IDLE : ST_EDGE;
      ST_RDA:   state_next = ST_RDB;
      ST_RDB:   state_next = ST_MAX;
      ST_MAX:   state_next = ST_NORM;
      ST_NORM: begin
        if (rpois || m == '0) state_next = ST_OUT;
        else if (m[SUM_W-1:NORM_W] == '0 && m[NORM_W-1]) state_next = ST_SQ;
      end
      ST_SQ:    if (sqcnt == 2'd3) state_next = ST_ROOT;
      ST_ROOT:  if (bitv[0]) state_next = ST_NDIV;
      ST_NDIV:  state_next = ST_NWAIT;
      ST_NWAIT: if (div_done) state_next = ST_NFIN;
      ST_NFIN:  state_next = ST_OUT;
      ST_OUT:   if (res_room) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    take      = (state == ST_IDLE) && q_valid;
    vwe       = take && (q_item.op == OP_WRITE);
    swe       = vwe;
    swaddr    = q_item.vertex_index;
    swdata    = '0;
    div_start = 1'b0;
    div_den   = den_r;
    res_push  = 1'b0;
    for (int k = 0; k < LANES; k++) div_num[k] = NUM_W'(mag[k]) << WEIGHT_SHIFT;
    case (state)
      ST_LDA:  vaddr = itm.corner_a;
      ST_LDB:  vaddr = itm.corner_b;
      default: vaddr = itm.corner_c;
    endcase
    case (state)
      ST_RDA, ST_RDB: saddr = itm.vertex_index;
      default:        saddr = pidx;
    endcase
    case (state)
      ST_MULA: begin
        if (len_zero) begin
          swe    = 1'b1;
          swaddr = pidx;
          swdata = srd;
          swdata.pois = 1'b1;
        end
      end
      ST_DIV: div_start = 1'b1;
      ST_ACC: begin
        swe    = 1'b1;
        swaddr = pidx;
        swdata = {s_new[0], s_new[1], s_new[2], srd.pois};
      end
      ST_NDIV: begin
        div_start = 1'b1;
        div_den   = DEN_W'(root) << 1;
        for (int k = 0; k < LANES; k++)
          div_num[k] = (NUM_W'(t[k][NORM_W-1:0]) << FRAC_SHIFT) + NUM_W'(root);
      end
      ST_OUT:  res_push = res_room;
      default: ;
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    vrd <= vmem[vaddr];
    if (vwe) vmem[q_item.vertex_index] <= q_item.coord;
  end

  always_ff @(posedge clk) begin
    srd <= smem[saddr];
    if (swe) smem[swaddr] <= swdata;
  end

  always_ff @(posedge clk) begin
    if (take) itm <= q_item;
    case (state)
      ST_LDB: va <= vrd;
      ST_LDC: vb <= vrd;
      ST_LDW: begin
        vc     <= vrd;
        corner <= 2'd0;
      end
      ST_EDGE: begin
        for (int k = 0; k < LANES; k++) begin
          e1[k] <= EDGE_W'(qc[k]) - EDGE_W'(pc[k]);
          e2[k] <= EDGE_W'(rc[k]) - EDGE_W'(pc[k]);
        end
      end
      ST_PROD: begin
        for (int k = 0; k < LANES; k++) begin
          sq1[k] <= LEN_W'(e1[k]) * LEN_W'(e1[k]);
          sq2[k] <= LEN_W'(e2[k]) * LEN_W'(e2[k]);
        end
        xp[0] <= LEN_W'(e1[1]) * LEN_W'(e2[2]);
        xp[1] <= LEN_W'(e1[2]) * LEN_W'(e2[1]);
        xp[2] <= LEN_W'(e1[2]) * LEN_W'(e2[0]);
        xp[3] <= LEN_W'(e1[0]) * LEN_W'(e2[2]);
        xp[4] <= LEN_W'(e1[0]) * LEN_W'(e2[1]);
        xp[5] <= LEN_W'(e1[1]) * LEN_W'(e2[0]);
      end
      ST_LEN: begin
        l1 <= sq1[0] + sq1[1] + sq1[2];
        l2 <= sq2[0] + sq2[1] + sq2[2];
        for (int k = 0; k < LANES; k++) begin
          cneg[k] <= cr[k][CROSS_W-1];
          mag[k]  <= cr[k][CROSS_W-1] ? MAG_W'(-cr[k]) : MAG_W'(cr[k]);
        end
      end
      ST_MULA: begin
        p0 <= PP_W'(l1) * PP_W'(l2[HALF_W-1:0]);
        if (len_zero) corner <= corner + 2'd1;
      end
      ST_MULB: p1 <= PP_W'(l1) * PP_W'(l2[LEN_W-1:HALF_W]);
      ST_MULC: den_r <= DEN_W'(p0) + (DEN_W'(p1) << HALF_W);
      ST_ACC:  corner <= corner + 2'd1;
      ST_RDB: begin
        rpois <= srd.pois;
        for (int k = 0; k < LANES; k++) begin
          sneg[k] <= s_cur[k][SUM_W-1];
          t[k]    <= s_cur[k][SUM_W-1] ? SUM_W'(-s_cur[k]) : SUM_W'(s_cur[k]);
        end
      end
      ST_MAX: begin
        m <= (t[0] > t[1]) ? ((t[0] > t[2]) ? t[0] : t[2]) : ((t[1] > t[2]) ? t[1] : t[2]);
      end
      ST_NORM: begin
        sqcnt <= 2'd0;
        v     <= '0;
        res_r <= '0;
        // one bit a cycle until the largest magnitude sits just below bit 31
        if (m[SUM_W-1:NORM_W] != '0) begin
          m <= m >> 1;
          for (int k = 0; k < LANES; k++) t[k] <= t[k] >> 1;
        end else if (!m[NORM_W-1]) begin
          m <= m << 1;
          for (int k = 0; k < LANES; k++) t[k] <= t[k] << 1;
        end
      end
      ST_SQ: begin
        sqcnt <= sqcnt + 2'd1;
        if (sqcnt != 2'd3)
          prod <= PROD_W'(t[sqcnt][NORM_W-1:0]) * PROD_W'(t[sqcnt][NORM_W-1:0]);
        if (sqcnt != 2'd0) v <= v + SUM_W'(prod);
        if (sqcnt == 2'd3) begin
          root <= '0;
          bitv <= SUM_W'(1) << (SUM_W - 2);
        end
      end
      ST_ROOT: begin
        if (v >= rb) begin
          v    <= v - rb;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      ST_NFIN: begin
        res_r.normal_x       <= nout[0];
        res_r.normal_y       <= nout[1];
        res_r.normal_z       <= nout[2];
        res_r.normal_defined <= 1'b1;
      end
      default: ;
    endcase
  end

  mvna_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  `ASSERT_IMPLIES(a_div_free, clk, rst, div_start, !div_busy)
  `ASSERT_NEXT(a_face_starts, clk, rst, take && q_item.op == OP_FACE, state == ST_LDA)

endmodule
